@@ src/sts_pkg.sv @@
// Shared types and constants for the sorted table search, swap and insert unit.
// Holds table sizing, the result status codes and the controller/datapath command
// and status structures. Depends on nothing.
`default_nettype none

package sts_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_SWAPPED  = 2'd0,
        ST_LAST     = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_MID,
        RD_SUCC,
        RD_SHIFT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SUCC_KEY,
        WR_MID_DATA,
        WR_SHIFT,
        WR_LOW_KEY
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    probe;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    shift_init;
        logic    shift_step;
        logic    count_inc;
        logic    finish;
        status_t fin_status;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic more;
        logic is_last;
        logic at_end;
        logic full;
        logic count_zero;
        logic shift_last;
    } stat_t;

    // Index to the narrow position field: zero-extended, then the low bits kept.
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, idx};
        return ext[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/sts_datapath.sv @@
// Datapath of the sorted table search unit: key table memory, search bounds,
// shift index, entry count and the registered result.
// Depends on sts_pkg; driven by sts_ctrl through sts_pkg::cmd_t.
`default_nettype none

module sts_datapath
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic signed [sts_pkg::KEY_W-1:0]  key,
    input  wire sts_pkg::cmd_t                     cmd,
    output sts_pkg::stat_t                         stat,
    output logic                                   done,
    output logic [sts_pkg::STATUS_W-1:0]           status,
    output logic [sts_pkg::POS_W-1:0]              position
);

    logic signed [sts_pkg::KEY_W-1:0] mem [sts_pkg::TABLE_DEPTH];
    logic signed [sts_pkg::KEY_W-1:0] rd_data_reg;
    logic signed [sts_pkg::KEY_W-1:0] key_reg;

    logic [sts_pkg::CNT_W-1:0] count_reg;
    logic [sts_pkg::CNT_W-1:0] low_reg;
    logic [sts_pkg::CNT_W-1:0] low_next;
    logic [sts_pkg::CNT_W-1:0] hi_reg;
    logic [sts_pkg::CNT_W-1:0] hi_next;
    logic [sts_pkg::IDX_W-1:0] mid_reg;
    logic [sts_pkg::IDX_W-1:0] mid_next;
    logic [sts_pkg::CNT_W-1:0] widx_reg;
    logic [sts_pkg::CNT_W-1:0] widx_next;

    logic [sts_pkg::CNT_W:0]   mid_sum;
    logic [sts_pkg::CNT_W-1:0] mid_ext;
    logic [sts_pkg::CNT_W-1:0] mid_inc;
    logic [sts_pkg::CNT_W-1:0] shift_src;
    logic                      key_eq;
    logic                      key_gt;

    logic [sts_pkg::IDX_W-1:0]        rd_addr;
    logic [sts_pkg::IDX_W-1:0]        wr_addr;
    logic signed [sts_pkg::KEY_W-1:0] wr_data;

    logic                              done_reg;
    sts_pkg::status_t                  status_reg;
    logic [sts_pkg::POS_W-1:0]         position_reg;
    logic [sts_pkg::POS_W-1:0]         position_next;

    assign mid_ext = {1'b0, mid_reg};
    assign mid_inc = mid_ext + sts_pkg::CNT_W'(1);
    assign key_eq  = (key_reg == rd_data_reg);
    assign key_gt  = (key_reg > rd_data_reg);

    // Bounds are kept as a half-open range [low, hi); a probe narrows it.
    always_comb
    begin
        low_next = low_reg;
        hi_next  = hi_reg;
        if (cmd.load)
        begin
            low_next = '0;
            hi_next  = count_reg;
        end
        else if (cmd.probe && !key_eq)
        begin
            if (key_gt)
            begin
                low_next = mid_inc;
            end
            else
            begin
                hi_next = mid_ext;
            end
        end
    end

    assign mid_sum  = {1'b0, low_next} + {1'b0, hi_next} - (sts_pkg::CNT_W+1)'(1);
    assign mid_next = mid_sum[sts_pkg::IDX_W:1];

    always_comb
    begin
        widx_next = widx_reg;
        if (cmd.shift_init)
        begin
            widx_next = count_reg;
        end
        else if (cmd.shift_step)
        begin
            widx_next = widx_reg - sts_pkg::CNT_W'(1);
        end
    end

    assign shift_src = widx_next - sts_pkg::CNT_W'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            sts_pkg::RD_MID:   rd_addr = mid_next;
            sts_pkg::RD_SUCC:  rd_addr = mid_inc[sts_pkg::IDX_W-1:0];
            sts_pkg::RD_SHIFT: rd_addr = shift_src[sts_pkg::IDX_W-1:0];
            default:           rd_addr = mid_next;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            sts_pkg::WR_SUCC_KEY:
            begin
                wr_addr = mid_inc[sts_pkg::IDX_W-1:0];
                wr_data = key_reg;
            end
            sts_pkg::WR_MID_DATA:
            begin
                wr_addr = mid_reg;
                wr_data = rd_data_reg;
            end
            sts_pkg::WR_SHIFT:
            begin
                wr_addr = widx_reg[sts_pkg::IDX_W-1:0];
                wr_data = rd_data_reg;
            end
            sts_pkg::WR_LOW_KEY:
            begin
                wr_addr = low_reg[sts_pkg::IDX_W-1:0];
                wr_data = key_reg;
            end
            default:
            begin
                wr_addr = low_reg[sts_pkg::IDX_W-1:0];
                wr_data = key_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.fin_status)
            sts_pkg::ST_SWAPPED:  position_next = sts_pkg::to_pos(mid_reg);
            sts_pkg::ST_LAST:     position_next = sts_pkg::to_pos(mid_reg);
            sts_pkg::ST_INSERTED: position_next = sts_pkg::to_pos(low_reg[sts_pkg::IDX_W-1:0]);
            sts_pkg::ST_FULL:     position_next = '0;
            default:              position_next = '0;
        endcase
    end

    // The read is registered and takes the old contents when the same
    // address is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.load)
        begin
            key_reg <= key;
        end
        if (cmd.finish)
        begin
            status_reg   <= cmd.fin_status;
            position_reg <= position_next;
        end
        low_reg  <= low_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        widx_reg <= widx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + sts_pkg::CNT_W'(1);
            end
        end
    end

    assign stat.hit        = key_eq;
    assign stat.more       = key_gt ? (mid_inc < hi_reg) : (low_reg < mid_ext);
    assign stat.is_last    = (mid_inc == count_reg);
    assign stat.at_end     = (low_reg == count_reg);
    assign stat.full       = (count_reg == sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH));
    assign stat.count_zero = (count_reg == '0);
    assign stat.shift_last = ((widx_reg - sts_pkg::CNT_W'(1)) == low_reg);

    assign done     = done_reg;
    assign status   = status_reg;
    assign position = position_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> !stat.full)
        else $error("insert into a full table");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |-> (low_reg < hi_reg) && (mid_ext >= low_reg) && (mid_ext < hi_reg))
        else $error("probe outside the search range");

    a_shift_above_low: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && (cmd.wr_sel == sts_pkg::WR_SHIFT)) |-> (widx_reg > low_reg))
        else $error("shift write at or below the insert index");

endmodule

`default_nettype wire

@@ src/sts_ctrl.sv @@
// Controller of the sorted table search unit: sequences search probes, the
// successor swap, the upward shift sweep and the insert write.
// Depends on sts_pkg; commands sts_datapath through sts_pkg::cmd_t.
`default_nettype none

module sts_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire sts_pkg::stat_t stat,
    output sts_pkg::cmd_t       cmd,
    output logic                busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_SWAP,
        S_SWAP_WR,
        S_MISS,
        S_SHIFT,
        S_INSERT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = sts_pkg::RD_MID;
        cmd.wr_sel     = sts_pkg::WR_LOW_KEY;
        cmd.fin_status = sts_pkg::ST_SWAPPED;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    cmd.rd_en = !stat.count_zero;
                    state_next = stat.count_zero ? S_MISS : S_PROBE;
                end
            end
            S_PROBE:
            begin
                // The next probe address is issued in the same cycle as the compare.
                cmd.probe = 1'b1;
                cmd.rd_en = 1'b1;
                if (stat.hit)
                begin
                    if (stat.is_last)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = sts_pkg::ST_LAST;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SWAP;
                    end
                end
                else if (!stat.more)
                begin
                    state_next = S_MISS;
                end
            end
            S_SWAP:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sts_pkg::RD_SUCC;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sts_pkg::WR_SUCC_KEY;
                state_next = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = sts_pkg::WR_MID_DATA;
                cmd.finish     = 1'b1;
                cmd.fin_status = sts_pkg::ST_SWAPPED;
                state_next     = S_IDLE;
            end
            S_MISS:
            begin
                if (stat.full)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = sts_pkg::ST_FULL;
                    state_next     = S_IDLE;
                end
                else if (stat.at_end)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = sts_pkg::WR_LOW_KEY;
                    cmd.count_inc  = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = sts_pkg::ST_INSERTED;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel     = sts_pkg::RD_SHIFT;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = sts_pkg::WR_SHIFT;
                cmd.shift_step = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = sts_pkg::RD_SHIFT;
                if (stat.shift_last)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = sts_pkg::WR_LOW_KEY;
                cmd.count_inc  = 1'b1;
                cmd.finish     = 1'b1;
                cmd.fin_status = sts_pkg::ST_INSERTED;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("accepted transaction did not start work");

    a_finish_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy_reg)
        else $error("still busy after the result was issued");

    a_swap_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP) |=> (state_reg == S_SWAP_WR) && cmd.finish)
        else $error("swap sequence broken");

endmodule

`default_nettype wire

@@ src/sorted_table_search_swap_insert_unit.sv @@
// Top level of the sorted table search, swap and insert unit.
// Joins sts_ctrl and sts_datapath; depends on sts_pkg.
//
//   Channel   Ports                             Direction  Transaction
//   command   start, busy, key[31:0]            in         start high while busy low
//   result    done, status[1:0], position[5:0]  out        done high for one cycle
//
// The search makes one probe per cycle, at most ceil(log2(count+1)) probes, on
// a single registered read port of the key table. A hit on the last entry ends
// there; a hit elsewhere swaps in S_SWAP and S_SWAP_WR. A miss on a full table,
// or an insert at the end of the filled part, ends in S_MISS; any other insert
// shifts the higher entries up in S_SHIFT, one per cycle, and writes the key in
// S_INSERT. The result appears the cycle after the last step; busy is low in
// that cycle, so the next command can be taken while it is shown. Reset clears
// the count. The receiver cannot hold a result off, so busy is the only stall.
`default_nettype none

module sorted_table_search_swap_insert_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [sts_pkg::KEY_W-1:0]  key,
    output logic                                   busy,
    output logic                                   done,
    output logic [sts_pkg::STATUS_W-1:0]           status,
    output logic [sts_pkg::POS_W-1:0]              position
);

    sts_pkg::cmd_t  cmd;
    sts_pkg::stat_t stat;

    sts_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sts_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .status   (status),
        .position (position)
    );

endmodule

`default_nettype wire

@@ verif/sts_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the sorted table search, swap and insert unit: it watches the
// command and result channels, keeps its own copy of the key table, and compares
// every result with the expected one. Depends on sts_pkg.
module sts_result_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [sts_pkg::KEY_W-1:0]    key,
    input  logic                                done,
    input  logic [sts_pkg::STATUS_W-1:0]        status,
    input  logic [sts_pkg::POS_W-1:0]           position,
    output int                                  mismatches,
    output int                                  outstanding
);
    import sts_pkg::*;

    typedef struct {
        status_t          st;
        logic [POS_W-1:0] pos;
    } lookup_result_t;

    logic signed [KEY_W-1:0] shadow_keys [0:TABLE_DEPTH-1];
    int                      shadow_count;
    lookup_result_t          awaited_results [$];

    initial
    begin
        mismatches   = 0;
        shadow_count = 0;
    end

    assign outstanding = awaited_results.size();

    task automatic report(input string what, input int exp_val, input int got_val);
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_val, got_val);
        mismatches++;
    endtask

    // Binary search over the filled part, then swap with the successor or insert.
    function automatic lookup_result_t search_and_update(input logic signed [KEY_W-1:0] k);
        lookup_result_t r;
        int             lo;
        int             hi;
        int             mid;
        int             i;
        bit             hit;
        lo  = 0;
        hi  = shadow_count - 1;
        mid = 0;
        hit = 1'b0;
        while (lo <= hi && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] == k)
                hit = 1'b1;
            else if (shadow_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        if (hit)
        begin
            if (mid != shadow_count - 1)
            begin
                shadow_keys[mid]     = shadow_keys[mid + 1];
                shadow_keys[mid + 1] = k;
                r.st = ST_SWAPPED;
            end
            else
                r.st = ST_LAST;
            r.pos = mid[POS_W-1:0];
        end
        else if (shadow_count >= TABLE_DEPTH)
        begin
            r.st  = ST_FULL;
            r.pos = '0;
        end
        else
        begin
            for (i = shadow_count; i > lo; i--)
                shadow_keys[i] = shadow_keys[i - 1];
            shadow_keys[lo] = k;
            shadow_count++;
            r.st  = ST_INSERTED;
            r.pos = lo[POS_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n)
        begin
            // The result shown in this cycle belongs to an earlier transaction, so it
            // is checked before a command taken at the same edge is predicted.
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no command outstanding (status %0d, position %0d)",
                             $realtime, status, position);
                    mismatches++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (status !== exp_r.st)
                        report("status", int'(exp_r.st), int'(status));
                    if (position !== exp_r.pos)
                        report("position", int'(exp_r.pos), int'(position));
                end
            end
            if (start && !busy)
                awaited_results.push_back(search_and_update(key));
        end
    end

endmodule

@@ verif/sorted_table_search_swap_insert_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted table search, swap and insert unit: drives the key
// commands and gives the verdict. Depends on sts_pkg, sts_result_checker and the unit.
module sorted_table_search_swap_insert_unit_tb;
    import sts_pkg::*;

    localparam int RANDOM_KEYS = 1025;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 100;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic signed [KEY_W-1:0] key;
    logic                    busy;
    logic                    done;
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        position;
    int                      mismatches;
    int                      outstanding;
    int                      cycles;
    bit                      gaps_on;
    logic signed [KEY_W-1:0] sent_keys [$];

    sorted_table_search_swap_insert_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key      (key),
        .busy     (busy),
        .done     (done),
        .status   (status),
        .position (position)
    );

    sts_result_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .key         (key),
        .done        (done),
        .status      (status),
        .position    (position),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sorted_table_search_swap_insert_unit] ERROR");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge, with start still high.
    task automatic send_key(input logic signed [KEY_W-1:0] k);
        while (gaps_on && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        key   <= k;
        sent_keys.push_back(k);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(input int n);
        int                      r;
        int                      fresh_pct;
        logic signed [KEY_W-1:0] k;
        r         = $urandom_range(0, 99);
        fresh_pct = (n < 500) ? 12 : 5;
        if (sent_keys.size() == 0 || r < fresh_pct)
            k = $urandom;
        else if (r < fresh_pct + 10)
        begin
            // A neighbour of a known key, which often misses next to that entry.
            k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end
        else if (r < fresh_pct + 14)
        begin
            case ($urandom_range(0, 3))
                0:       k = 32'sh7FFF_FFFF;
                1:       k = 32'sh8000_0000;
                2:       k = -1;
                default: k = 0;
            endcase
        end
        else
            k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        return k;
    endfunction

    initial
    begin
        int n;
        cycles  = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        key     = '0;
        gaps_on = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table first, then inserts at the front, the back and the middle.
        send_key(0);
        send_key(32'sh7FFF_FFFF);
        send_key(32'sh8000_0000);
        send_key(-1);
        send_key(1);
        send_key(32'sh4000_0000);
        send_key(32'shC000_0000);
        send_key(32'sh7FFF_FFFE);
        // Hit on the last entry, then hits that swap with the successor.
        send_key(32'sh7FFF_FFFF);
        send_key(32'sh8000_0000);
        send_key(32'sh8000_0000);
        send_key(0);
        send_key(-1);
        // The swaps above have broken the order, so some of these miss and duplicate.
        send_key(32'sh8000_0000);
        send_key(0);
        send_key(32'sh5555_5555);
        send_key(32'shAAAA_AAAA);
        send_key(32'sh7FFF_FFFE);

        for (n = 0; n < RANDOM_KEYS; n++)
        begin
            gaps_on = !(n >= 400 && n < 550);
            send_key(pick_key(n));
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0)
            $display("[sorted_table_search_swap_insert_unit] OK");
        else
            $display("[sorted_table_search_swap_insert_unit] ERROR");
        $finish;
    end

endmodule
